/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bipf check failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bipf check failed");

`endif

/* src/bipf_pkg.sv */
// ----------------------------------------------------------------------------
// bipf_pkg
// shared constants, codes and types of the peak finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bipf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 24;

    localparam int PIX_W      = 24;
    localparam int DIM_W      = 11;
    localparam int TOL_W      = 24;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [PIX_W-1:0] PIXEL_MASK = (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} :
        PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_TOLERANCE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FR_PIXEL,
        FR_FLUSH
    } front_state_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [TOL_W-1:0] tol;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{width: 11'd1024, height: 11'd1024, tol: '0};

    typedef struct packed {
        logic             hit;
        logic [PIX_W-1:0] value;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } cand_t;

    typedef struct packed {
        logic  frame_last;
        cand_t cand_a;
        cand_t cand_b;
    } qent_t;

endpackage

`default_nettype wire

/* src/bipf_ifs.sv */
// ----------------------------------------------------------------------------
// bipf interfaces
// valid/ready channels for pixels, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bipf_pixel_if import bipf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface bipf_result_if import bipf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic             unique_res;
    logic [DIM_W-1:0] peak_row;
    logic [DIM_W-1:0] peak_column;
    logic [PIX_W-1:0] peak_value;

    modport source (output valid, output found, output unique_res, output peak_row,
        output peak_column, output peak_value, input ready);
    modport sink (input valid, input found, input unique_res, input peak_row,
        input peak_column, input peak_value, output ready);
endinterface

interface bipf_cfg_if import bipf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

/* src/bipf_queue.sv */
// ----------------------------------------------------------------------------
// bipf_queue
// short queue of candidate pairs between the window front and the tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bipf_queue
    import bipf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qent_t             wdata,
    input  logic              pop,
    output qent_t             rdata,
    output logic              rvalid,
    output logic [QCNT_W-1:0] count
);

    qent_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign rvalid = (count_reg != '0);
    assign rdata  = slot_reg[rd_ptr_reg];
    assign count  = count_reg;
    assign do_pop = pop && rvalid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* src/bipf_front.sv */
// ----------------------------------------------------------------------------
// bipf_front
// raster counters, two line stores, 3x3 window and the peak test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bipf_front
    import bipf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bipf_pixel_if.sink        pix,
    input  cfg_t              cfg_q,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output qent_t             q_wdata
);

    typedef struct packed {
        logic             is_pix;
        logic             en;
        logic             has_top;
        logic             has_bot;
        logic             row_end;
        logic             frame_last;
        logic [DIM_W-1:0] crow;
        logic [DIM_W-1:0] col;
    } slot_t;

    front_state_t      state_reg, state_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  fcol_reg, fcol_next;
    logic [DIM_W-1:0]  frow_reg, frow_next;

    logic [DIM_W-1:0]  w_eff, h_eff, cur_col;
    logic [ADDR_W-1:0] idx;
    logic [QCNT_W:0]   used;
    logic              issue_ok, pix_take, flush_take, issue;
    logic              row_end, frame_end;
    logic [PIX_W-1:0]  px_in;
    slot_t             slot;

    logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  upper_rd_reg, middle_rd_reg;
    logic              fwd_reg;
    logic [PIX_W-1:0]  fwd_data_reg;
    logic [PIX_W-1:0]  upper_val;

    logic              s1_valid_reg, s2_valid_reg;
    slot_t             s1_slot_reg, s2_slot_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [ADDR_W-1:0] s1_idx_reg;

    logic [PIX_W-1:0]  top_reg [3];
    logic [PIX_W-1:0]  mid_reg [3];
    logic [PIX_W-1:0]  bot_reg [3];

    logic              hl_a, hl_b, ht, hb, ok_a, ok_b;

    function automatic logic beats(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] nb,
        input logic [TOL_W-1:0] tol);
        logic [PIX_W:0] lim;
        lim = {1'b0, nb} + (PIX_W+1)'(tol);
        return {1'b0, p} > lim;
    endfunction

    // frame geometry and slot issue
    always_comb
    begin
        w_eff = cfg_q.width;
        if (cfg_q.width == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (32'(cfg_q.width) > MAX_WIDTH)
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = (cfg_q.height == '0) ? DIM_W'(1) : cfg_q.height;

        used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg)
            + (QCNT_W+1)'(s2_valid_reg);
        issue_ok = used < (QCNT_W+1)'(QDEPTH);

        cur_col   = (state_reg == FR_FLUSH) ? fcol_reg : col_reg;
        row_end   = cur_col >= w_eff;
        frame_end = row_end && (row_reg >= h_eff);
        if (32'(cur_col) > MAX_WIDTH)
        begin
            idx = ADDR_W'(MAX_WIDTH - 1);
        end
        else
        begin
            idx = ADDR_W'(cur_col - 1'b1);
        end

        px_in = pix.pixel & PIXEL_MASK;
    end

    assign pix.ready  = (state_reg == FR_PIXEL) && issue_ok;
    assign pix_take   = pix.valid && pix.ready;
    assign flush_take = (state_reg == FR_FLUSH) && issue_ok;
    assign issue      = pix_take || flush_take;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        fcol_next  = fcol_reg;
        frow_next  = frow_reg;
        slot       = '0;
        unique case (state_reg)
            FR_PIXEL:
            begin
                slot.is_pix     = 1'b1;
                slot.en         = row_reg >= DIM_W'(2);
                slot.has_top    = row_reg >= DIM_W'(3);
                slot.has_bot    = 1'b1;
                slot.row_end    = row_end;
                slot.frame_last = 1'b0;
                slot.crow       = row_reg - 1'b1;
                slot.col        = col_reg;
                if (pix_take)
                begin
                    if (row_end)
                    begin
                        col_next = DIM_W'(1);
                        if (frame_end)
                        begin
                            row_next   = DIM_W'(1);
                            fcol_next  = DIM_W'(1);
                            frow_next  = row_reg;
                            state_next = FR_FLUSH;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            if (row_next == '0)
                            begin
                                row_next = DIM_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            FR_FLUSH:
            begin
                // last row judged as a row with no neighbours below
                slot.is_pix     = 1'b0;
                slot.en         = 1'b1;
                slot.has_top    = frow_reg >= DIM_W'(2);
                slot.has_bot    = 1'b0;
                slot.row_end    = row_end;
                slot.frame_last = row_end;
                slot.crow       = frow_reg;
                slot.col        = fcol_reg;
                if (flush_take)
                begin
                    if (row_end)
                    begin
                        state_next = FR_PIXEL;
                    end
                    else
                    begin
                        fcol_next = fcol_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = FR_PIXEL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_PIXEL;
            col_reg      <= DIM_W'(1);
            row_reg      <= DIM_W'(1);
            fcol_reg     <= DIM_W'(1);
            frow_reg     <= DIM_W'(1);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            fcol_reg     <= fcol_next;
            frow_reg     <= frow_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            middle_rd_reg <= middle_mem[idx];
        end
        if (pix_take)
        begin
            middle_mem[idx] <= px_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            upper_rd_reg <= upper_mem[idx];
        end
        if (s1_valid_reg && s1_slot_reg.is_pix)
        begin
            upper_mem[s1_idx_reg] <= middle_rd_reg;
        end
    end

    // bypass for an upper read that meets the pending write of the same column
    assign upper_val = fwd_reg ? fwd_data_reg : upper_rd_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            fwd_reg      <= s1_valid_reg && s1_slot_reg.is_pix && (s1_idx_reg == idx);
            fwd_data_reg <= middle_rd_reg;
            s1_slot_reg  <= slot;
            s1_px_reg    <= px_in;
            s1_idx_reg   <= idx;
        end
        if (s1_valid_reg)
        begin
            top_reg[0]  <= top_reg[1];
            top_reg[1]  <= top_reg[2];
            top_reg[2]  <= upper_val;
            mid_reg[0]  <= mid_reg[1];
            mid_reg[1]  <= mid_reg[2];
            mid_reg[2]  <= middle_rd_reg;
            bot_reg[0]  <= bot_reg[1];
            bot_reg[1]  <= bot_reg[2];
            bot_reg[2]  <= s1_px_reg;
            s2_slot_reg <= s1_slot_reg;
        end
    end

    // peak test on the window
    always_comb
    begin
        ht   = s2_slot_reg.has_top;
        hb   = s2_slot_reg.has_bot;
        hl_a = s2_slot_reg.col >= DIM_W'(3);
        hl_b = s2_slot_reg.col >= DIM_W'(2);

        ok_a = s2_slot_reg.en && hl_b
            && (!ht || beats(mid_reg[1], top_reg[1], cfg_q.tol))
            && (!hb || beats(mid_reg[1], bot_reg[1], cfg_q.tol))
            && (!hl_a || beats(mid_reg[1], mid_reg[0], cfg_q.tol))
            && beats(mid_reg[1], mid_reg[2], cfg_q.tol)
            && (!(ht && hl_a) || beats(mid_reg[1], top_reg[0], cfg_q.tol))
            && (!ht || beats(mid_reg[1], top_reg[2], cfg_q.tol))
            && (!(hb && hl_a) || beats(mid_reg[1], bot_reg[0], cfg_q.tol))
            && (!hb || beats(mid_reg[1], bot_reg[2], cfg_q.tol));

        // right edge of the row
        ok_b = s2_slot_reg.en && s2_slot_reg.row_end
            && (!ht || beats(mid_reg[2], top_reg[2], cfg_q.tol))
            && (!hb || beats(mid_reg[2], bot_reg[2], cfg_q.tol))
            && (!hl_b || beats(mid_reg[2], mid_reg[1], cfg_q.tol))
            && (!(ht && hl_b) || beats(mid_reg[2], top_reg[1], cfg_q.tol))
            && (!(hb && hl_b) || beats(mid_reg[2], bot_reg[1], cfg_q.tol));

        q_wdata.frame_last   = s2_slot_reg.frame_last;
        q_wdata.cand_a.hit   = ok_a;
        q_wdata.cand_a.value = mid_reg[1];
        q_wdata.cand_a.row   = s2_slot_reg.crow;
        q_wdata.cand_a.col   = s2_slot_reg.col - 1'b1;
        q_wdata.cand_b.hit   = ok_b;
        q_wdata.cand_b.value = mid_reg[2];
        q_wdata.cand_b.row   = s2_slot_reg.crow;
        q_wdata.cand_b.col   = s2_slot_reg.col;
    end

    assign q_push = s2_valid_reg;

endmodule

`default_nettype wire

/* src/bipf_back.sv */
// ----------------------------------------------------------------------------
// bipf_back
// brightest peak tracker and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bipf_back
    import bipf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  qent_t         q_rdata,
    output logic          q_pop,
    bipf_result_if.source res
);

    typedef struct packed {
        logic             found;
        logic             uniq;
        logic [PIX_W-1:0] value;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } best_t;

    localparam best_t BEST_CLEAR = '{found: 1'b0, uniq: 1'b1, value: '0, row: '0, col: '0};

    best_t            best_reg;
    best_t            after_a, after_b;
    logic             out_valid_reg;
    logic             out_found_reg, out_unique_reg;
    logic [DIM_W-1:0] out_row_reg, out_col_reg;
    logic [PIX_W-1:0] out_value_reg;
    logic             end_pop;

    function automatic best_t track(input best_t b, input cand_t c);
        best_t n;
        n = b;
        if (c.hit)
        begin
            if (!b.found || (c.value > b.value))
            begin
                n.found = 1'b1;
                n.uniq  = 1'b1;
                n.value = c.value;
                n.row   = c.row;
                n.col   = c.col;
            end
            else if (c.value == b.value)
            begin
                n.uniq = 1'b0;
            end
        end
        return n;
    endfunction

    assign q_pop   = q_valid && (!q_rdata.frame_last || !out_valid_reg || res.ready);
    assign end_pop = q_pop && q_rdata.frame_last;
    assign after_a = track(best_reg, q_rdata.cand_a);
    assign after_b = track(after_a, q_rdata.cand_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= BEST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                best_reg <= end_pop ? BEST_CLEAR : after_b;
            end
            if (end_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_pop)
        begin
            out_found_reg  <= after_b.found;
            out_unique_reg <= after_b.found && after_b.uniq;
            out_row_reg    <= after_b.row;
            out_col_reg    <= after_b.col;
            out_value_reg  <= after_b.value;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.found       = out_found_reg;
    assign res.unique_res  = out_unique_reg;
    assign res.peak_row    = out_row_reg;
    assign res.peak_column = out_col_reg;
    assign res.peak_value  = out_value_reg;

endmodule

`default_nettype wire

/* src/brightest_isolated_peak_finder.sv */
// ----------------------------------------------------------------------------
// brightest_isolated_peak_finder
// finds the brightest 3x3 local maximum of a raster frame
//
// channel  direction  payload                                      handshake
// pix      in         pixel                                        valid/ready
// cfg      in         reg_index, reg_data                          valid/ready
// res      out        found, unique_res, peak_row, peak_column,    valid/ready
//                     peak_value
//
// one pixel per cycle through a frame unless the queue is full; after the last
// pixel the input holds off while the last row is read back from line stores
// the result is registered when the last read-back entry leaves the queue
// a stalled result fills a 4-entry candidate queue, then pix.ready drops
// rst_n clears counters and frame statistics; line stores are not cleared
// cfg.ready is always high; a write to an unused index is dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brightest_isolated_peak_finder
    import bipf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bipf_pixel_if.sink    pix,
    bipf_cfg_if.sink      cfg,
    bipf_result_if.source res
);

    cfg_t              cfg_reg, cfg_next;
    logic [QCNT_W-1:0] q_count;
    logic              q_push, q_pop, q_valid;
    qent_t             q_wdata, q_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                CFG_WIDTH:     cfg_next.width  = cfg.reg_data[DIM_W-1:0];
                CFG_HEIGHT:    cfg_next.height = cfg.reg_data[DIM_W-1:0];
                CFG_TOLERANCE: cfg_next.tol    = cfg.reg_data[TOL_W-1:0];
                default:       cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bipf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .cfg_q   (cfg_reg),
        .q_count (q_count),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    bipf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .rvalid (q_valid),
        .count  (q_count)
    );

    bipf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

`default_nettype wire

/* src/bipf_checker.sv */
// ----------------------------------------------------------------------------
// bipf_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bipf_checker
    import bipf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_found,
    input logic             res_unique,
    input logic [DIM_W-1:0] res_row,
    input logic [DIM_W-1:0] res_col,
    input logic [PIX_W-1:0] res_value
);

    `ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)
    `ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(res_found) && $stable(res_unique) && $stable(res_row) && $stable(res_col) && $stable(res_value))
    `ASSERT_IMP(a_none_zero, res_valid && !res_found, !res_unique && (res_row == '0) && (res_col == '0) && (res_value == '0))
    `ASSERT_IMP(a_found_pos, res_valid && res_found, (res_row != '0) && (res_col != '0))
    `ASSERT_IMP(a_unique_found, res_valid && res_unique, res_found)

endmodule

bind brightest_isolated_peak_finder bipf_checker u_bipf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_found  (res.found),
    .res_unique (res.unique_res),
    .res_row    (res.peak_row),
    .res_col    (res.peak_column),
    .res_value  (res.peak_value)
);

`default_nettype wire

/* sim/bipf_peak_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipf_peak_check
// Watches the pixel, register and result channels of the peak finder. It keeps
// its own copy of the line stores, the 3x3 window, the frame counters and the
// brightest-peak statistics. From these it works out the result of every frame.
// Each result transaction is compared field by field with the oldest result
// still waiting. The number of mismatches and of frames still owed are handed
// to the testbench top.
// ----------------------------------------------------------------------------
module bipf_peak_check
    import bipf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  logic                  pixel_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  reg_index,
    input  logic [CFG_DATA_W-1:0] reg_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  logic                  found,
    input  logic                  unique_res,
    input  logic [DIM_W-1:0]      peak_row,
    input  logic [DIM_W-1:0]      peak_column,
    input  logic [PIX_W-1:0]      peak_value,
    output int                    frames_pending,
    output int                    mismatches
);

    typedef struct packed {
        logic             found;
        logic             unique_res;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [PIX_W-1:0] value;
    } frame_peak_t;

    // index 0 left, 1 center, 2 right
    typedef bit [2:0][PIX_W-1:0] nbhd_row_t;

    bit [PIX_W-1:0] upper_line [MAX_WIDTH];
    bit [PIX_W-1:0] middle_line [MAX_WIDTH];
    nbhd_row_t      win_top;
    nbhd_row_t      win_mid;
    nbhd_row_t      win_bot;
    bit [DIM_W-1:0] width_reg;
    bit [DIM_W-1:0] height_reg;
    bit [TOL_W-1:0] tol_reg;
    bit [DIM_W-1:0] row_cnt;
    bit [DIM_W-1:0] col_cnt;
    bit [DIM_W-1:0] best_row;
    bit [DIM_W-1:0] best_col;
    bit [PIX_W-1:0] best_val;
    bit             have_peak;
    bit             single_peak;
    frame_peak_t    frame_peaks [$];
    frame_peak_t    oldest;
    int             fail_cnt = 0;

    assign mismatches = fail_cnt;

    function automatic bit exceeds(bit [PIX_W-1:0] p, bit [PIX_W-1:0] nb);
        return {1'b0, p} > {1'b0, nb} + {1'b0, tol_reg};
    endfunction

    function void clear_stats();
        best_val    = '0;
        best_row    = '0;
        best_col    = '0;
        have_peak   = 1'b0;
        single_peak = 1'b1;
    endfunction

    // judge the center of a window; absent neighbours are skipped
    function void judge(bit [DIM_W-1:0] r, bit [DIM_W-1:0] c, nbhd_row_t t,
                        nbhd_row_t m, nbhd_row_t b, bit ht, bit hb, bit hl, bit hr);
        bit [PIX_W-1:0] p;
        p = m[1];
        if (ht && !exceeds(p, t[1])) return;
        if (hb && !exceeds(p, b[1])) return;
        if (hl && !exceeds(p, m[0])) return;
        if (hr && !exceeds(p, m[2])) return;
        if (ht && hl && !exceeds(p, t[0])) return;
        if (ht && hr && !exceeds(p, t[2])) return;
        if (hb && hl && !exceeds(p, b[0])) return;
        if (hb && hr && !exceeds(p, b[2])) return;
        if (!have_peak || p > best_val) begin
            have_peak   = 1'b1;
            single_peak = 1'b1;
            best_val    = p;
            best_row    = r;
            best_col    = c;
        end
        else if (p == best_val) begin
            single_peak = 1'b0;
        end
    endfunction

    function void take_pixel(bit [PIX_W-1:0] px);
        bit [DIM_W-1:0] w;
        bit [DIM_W-1:0] h;
        bit [DIM_W-1:0] c;
        bit [DIM_W-1:0] r;
        int             idx;
        int             x;
        bit             row_end;
        bit             frame_end;
        bit             hl;
        bit             hr;
        nbhd_row_t      t;
        nbhd_row_t      m;
        nbhd_row_t      b;
        frame_peak_t    res_exp;
        w = (width_reg == 0) ? DIM_W'(1) : width_reg;
        h = (height_reg == 0) ? DIM_W'(1) : height_reg;
        if (w > MAX_WIDTH) w = DIM_W'(MAX_WIDTH);
        c = col_cnt;
        r = row_cnt;
        idx = int'(c) - 1;
        if (idx >= MAX_WIDTH) idx = MAX_WIDTH - 1;

        win_top = {upper_line[idx], win_top[2], win_top[1]};
        win_mid = {middle_line[idx], win_mid[2], win_mid[1]};
        win_bot = {px, win_bot[2], win_bot[1]};
        upper_line[idx]  = middle_line[idx];
        middle_line[idx] = px;

        row_end   = c >= w;
        frame_end = row_end && r >= h;

        if (r >= 2) begin
            if (c >= 2)
                judge(r - 1'b1, c - 1'b1, win_top, win_mid, win_bot, r >= 3, 1'b1, c >= 3, 1'b1);
            if (row_end) begin
                t = {PIX_W'(0), win_top[2], win_top[1]};
                m = {PIX_W'(0), win_mid[2], win_mid[1]};
                b = {PIX_W'(0), win_bot[2], win_bot[1]};
                judge(r - 1'b1, c, t, m, b, r >= 3, 1'b1, c >= 2, 1'b0);
            end
        end

        // last row: read back from the line stores, nothing below
        if (frame_end) begin
            b = '0;
            for (x = 0; x < w; x++) begin
                hl = x > 0;
                hr = x + 1 < w;
                t[0] = hl ? upper_line[x - 1] : '0;
                t[1] = upper_line[x];
                t[2] = hr ? upper_line[x + 1] : '0;
                m[0] = hl ? middle_line[x - 1] : '0;
                m[1] = middle_line[x];
                m[2] = hr ? middle_line[x + 1] : '0;
                judge(r, DIM_W'(x + 1), t, m, b, r >= 2, 1'b0, hl, hr);
            end
        end

        if (row_end) begin
            col_cnt = DIM_W'(1);
            row_cnt = frame_end ? DIM_W'(1) : r + 1'b1;
            if (row_cnt == 0) row_cnt = DIM_W'(1);
        end
        else begin
            col_cnt = c + 1'b1;
        end

        if (frame_end) begin
            res_exp.found      = have_peak;
            res_exp.unique_res = have_peak && single_peak;
            res_exp.row        = have_peak ? best_row : '0;
            res_exp.col        = have_peak ? best_col : '0;
            res_exp.value      = have_peak ? best_val : '0;
            frame_peaks.push_back(res_exp);
            clear_stats();
        end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            tol_reg    = '0;
            win_top    = '0;
            win_mid    = '0;
            win_bot    = '0;
            row_cnt    = DIM_W'(1);
            col_cnt    = DIM_W'(1);
            clear_stats();
            frame_peaks.delete();
            frames_pending <= 0;
        end
        else begin
            if (res_valid && res_ready) begin
                if (frame_peaks.size() == 0) begin
                    $display("%0t: result with no frame pending, got found %0d value 0x%0h",
                             $time, found, peak_value);
                    fail_cnt++;
                end
                else begin
                    oldest = frame_peaks.pop_front();
                    check_field("found", 32'(oldest.found), 32'(found));
                    check_field("unique_res", 32'(oldest.unique_res), 32'(unique_res));
                    check_field("peak_row", 32'(oldest.row), 32'(peak_row));
                    check_field("peak_column", 32'(oldest.col), 32'(peak_column));
                    check_field("peak_value", 32'(oldest.value), 32'(peak_value));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_index)
                    CFG_WIDTH:     width_reg = reg_data[DIM_W-1:0];
                    CFG_HEIGHT:    height_reg = reg_data[DIM_W-1:0];
                    CFG_TOLERANCE: tol_reg = reg_data[TOL_W-1:0];
                    default:       ;
                endcase
            end
            if (pixel_valid && pixel_ready)
                take_pixel(pixel & PIXEL_MASK);
            frames_pending <= frame_peaks.size();
        end
    end

endmodule

/* sim/tb_brightest_isolated_peak_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brightest_isolated_peak_finder
// Streams frames through the peak finder and reports the verdict. A short set
// of hand-built frames comes first: single pixels at the value extremes,
// dimensions of zero, a flat frame with no peak, tied peaks and a brighter
// peak after a tie. Random frames follow, with mixed sizes, tolerances and
// content, and then the widest frame at a saturated width and a tall
// single-column frame.
// Registers change only while no frame is in flight. Both sides stall at
// random, except in one quiet stretch. The checker beside the block does the
// prediction and the comparison.
// ----------------------------------------------------------------------------
module tb_brightest_isolated_peak_finder;
    import bipf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int                   RANDOM_PIXELS = 320;

    logic           clk;
    logic           rst_n;
    bit             calm;
    int             frames_pending;
    int             mismatches;
    int unsigned    random_pixels;
    int unsigned    w;
    int unsigned    h;
    int unsigned    tol;
    bit [PIX_W-1:0] frame_pixels [$];

    bipf_pixel_if  pix_if ();
    bipf_cfg_if    cfg_if ();
    bipf_result_if res_if ();

    brightest_isolated_peak_finder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    bipf_peak_check u_peak_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pix_if.valid),
        .pixel_ready    (pix_if.ready),
        .pixel          (pix_if.pixel),
        .cfg_valid      (cfg_if.valid),
        .cfg_ready      (cfg_if.ready),
        .reg_index      (cfg_if.reg_index),
        .reg_data       (cfg_if.reg_data),
        .res_valid      (res_if.valid),
        .res_ready      (res_if.ready),
        .found          (res_if.found),
        .unique_res     (res_if.unique_res),
        .peak_row       (res_if.peak_row),
        .peak_column    (res_if.peak_column),
        .peak_value     (res_if.peak_value),
        .frames_pending (frames_pending),
        .mismatches     (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        #8_000_000;
        $display("tb_brightest_isolated_peak_finder: done, errors");
        $finish;
    end

    task automatic wait_idle();
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.reg_data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    task automatic send_pixel(bit [PIX_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // registers go in only once every result owed has been taken
    task automatic send_frame(int unsigned fw, int unsigned fh, int unsigned ftol, bit probe);
        wait_idle();
        put_reg(CFG_WIDTH, CFG_DATA_W'(fw));
        put_reg(CFG_HEIGHT, CFG_DATA_W'(fh));
        put_reg(CFG_TOLERANCE, CFG_DATA_W'(ftol));
        if (probe)
            put_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        cfg_if.valid <= 1'b0;
        foreach (frame_pixels[i])
            send_pixel(frame_pixels[i]);
        pix_if.valid <= 1'b0;
    endtask

    function automatic void fill_frame(int unsigned n, int unsigned mode);
        bit [PIX_W-1:0] spike;
        frame_pixels.delete();
        spike = PIX_W'($urandom_range(16, 24'hFFFFFE));
        repeat (n)
        begin
            case (mode)
                0: frame_pixels.push_back(PIX_W'($urandom_range(0, 24'hFFFFFF)));
                1: frame_pixels.push_back(PIX_W'($urandom_range(0, 3)));
                2: frame_pixels.push_back(($urandom_range(0, 5) == 0) ?
                       spike + PIX_W'($urandom_range(0, 1)) : PIX_W'($urandom_range(0, 15)));
                default: frame_pixels.push_back(24'hFFFFFF - PIX_W'($urandom_range(0, 3)));
            endcase
        end
    endfunction

    initial
    begin
        calm             <= 1'b0;
        pix_if.valid     <= 1'b0;
        pix_if.pixel     <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= '0;
        cfg_if.reg_data  <= '0;
        rst_n            <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero dimensions act as one; zero-valued lone pixel is a peak
        frame_pixels = '{24'h000000};
        send_frame(0, 0, 0, 1'b1);
        frame_pixels = '{24'hFFFFFF};
        send_frame(1, 1, 24'hFFFFFF, 1'b0);
        // flat frame, no peak
        frame_pixels = '{24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
                         24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA};
        send_frame(3, 3, 0, 1'b0);
        // tied peaks just above tolerance
        frame_pixels = '{24'd5, 24'd1, 24'd5, 24'd1};
        send_frame(4, 1, 3, 1'b0);
        // brighter peak after a tie
        frame_pixels = '{24'd7, 24'd1, 24'd7, 24'd1, 24'd9};
        send_frame(5, 1, 0, 1'b0);

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            calm <= (random_pixels >= 100 && random_pixels < 260);
            if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(1, 32);
                h = $urandom_range(1, 12);
            end
            else
            begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 6);
            end
            case ($urandom_range(0, 9))
                6, 7:    tol = $urandom_range(0, 7);
                8:       tol = $urandom_range(0, 24'hFFFFFF);
                9:       tol = 24'hFFFFFF;
                default: tol = 0;
            endcase
            fill_frame(w * h, $urandom_range(0, 3));
            send_frame(w, h, tol, 1'b0);
            random_pixels += w * h;
        end
        calm <= 1'b0;

        // widest frame at a saturated width, then a tall single column
        fill_frame(MAX_WIDTH, 2);
        send_frame(11'h7FF, 1, 0, 1'b0);
        fill_frame(48, 0);
        send_frame(1, 48, $urandom_range(0, 3), 1'b0);

        wait_idle();
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("tb_brightest_isolated_peak_finder: done, clean");
        else
            $display("tb_brightest_isolated_peak_finder: done, errors");
        $finish;
    end

endmodule
